/* rtl/thq_pkg.sv */
`timescale 1ns / 1ps

package thq_pkg;

    // Store geometry: (MAX_CELLS+1) squared vertices, split into four banks
    // by the parity of x and z so that the four corners of a cell never
    // share a bank.
    localparam int MAX_CELLS  = 256;
    localparam int FRAC_BITS  = 8;
    localparam int POS_W      = 17;
    localparam int COORD_W    = 9;
    localparam int HEIGHT_W   = 8;
    localparam int SCALE_W    = 16;
    localparam int OUT_W      = 24;
    localparam int INT_W      = POS_W - 1 - FRAC_BITS;
    localparam int ONE        = 1 << FRAC_BITS;

    localparam int HALF       = MAX_CELLS / 2 + 1;
    localparam int BANK_DEPTH = HALF * HALF;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int NUM_BANKS  = 4;

    // Interpolation widths
    localparam int WGT_W      = FRAC_BITS + 1;
    localparam int DIFF_W     = HEIGHT_W + 1;
    localparam int IACC_W     = HEIGHT_W + FRAC_BITS;
    localparam int ACC_W      = IACC_W + 3;
    localparam int PROD_W     = IACC_W + SCALE_W;

    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 2'd2;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Classified item as handed from front to back
    typedef struct packed {
        logic                 is_query;
        logic                 wr_en;
        logic                 in_range;
        logic                 lower;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   z;
        logic [HEIGHT_W-1:0]  sample;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fz;
    } thq_cmd_t;

endpackage

/* rtl/thq_ram.sv */
`timescale 1ns / 1ps

module thq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read; read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

/* rtl/thq_front.sv */
`timescale 1ns / 1ps

module thq_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,
    input  logic                          s_tuser,
    input  logic [thq_pkg::COORD_W-1:0]   grid_width,
    input  logic [thq_pkg::COORD_W-1:0]   grid_depth,
    input  logic                          queue_full,
    output logic                          push,
    output thq_pkg::thq_cmd_t             push_cmd
);

    import thq_pkg::*;

    logic [COORD_W-1:0]   vertex_x;
    logic [COORD_W-1:0]   vertex_z;
    logic [HEIGHT_W-1:0]  height_sample;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_z;
    logic [INT_W-1:0]     ix;
    logic [INT_W-1:0]     iz;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fz;
    logic [COORD_W-1:0]   eff_w;
    logic [COORD_W-1:0]   eff_d;
    logic [FRAC_BITS:0]   frac_sum;
    logic                 in_grid;

    // Unpack the item
    assign vertex_x      = s_tdata[8:0];
    assign vertex_z      = s_tdata[17:9];
    assign height_sample = s_tdata[25:18];
    assign pos_x         = s_tdata[42:26];
    assign pos_z         = s_tdata[59:43];

    assign ix = pos_x[POS_W-2:FRAC_BITS];
    assign iz = pos_z[POS_W-2:FRAC_BITS];
    assign fx = pos_x[FRAC_BITS-1:0];
    assign fz = pos_z[FRAC_BITS-1:0];

    // Grid sizes above the store clamp to the store
    assign eff_w = (grid_width > COORD_W'(MAX_CELLS)) ? COORD_W'(MAX_CELLS) : grid_width;
    assign eff_d = (grid_depth > COORD_W'(MAX_CELLS)) ? COORD_W'(MAX_CELLS) : grid_depth;

    assign in_grid = !pos_x[POS_W-1] && !pos_z[POS_W-1]
                     && (COORD_W'(ix) < eff_w) && (COORD_W'(iz) < eff_d);

    assign frac_sum = {1'b0, fx} + {1'b0, fz};

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    // Classify: writes carry the vertex, queries the cell and triangle
    always_comb
    begin
        push_cmd          = '0;
        push_cmd.sample   = height_sample;
        push_cmd.fx       = fx;
        push_cmd.fz       = fz;
        push_cmd.lower    = (frac_sum <= (FRAC_BITS + 1)'(ONE));
        if (s_tuser == KIND_QUERY)
        begin
            push_cmd.is_query = 1'b1;
            push_cmd.in_range = in_grid;
            push_cmd.x        = COORD_W'(ix);
            push_cmd.z        = COORD_W'(iz);
        end
        else
        begin
            push_cmd.wr_en = (vertex_x <= COORD_W'(MAX_CELLS))
                             && (vertex_z <= COORD_W'(MAX_CELLS));
            push_cmd.x     = vertex_x;
            push_cmd.z     = vertex_z;
        end
    end

endmodule

/* rtl/thq_queue.sv */
`timescale 1ns / 1ps

module thq_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  thq_pkg::thq_cmd_t  push_cmd,
    input  logic               pop,
    output thq_pkg::thq_cmd_t  pop_cmd,
    output logic               full,
    output logic               empty
);

    import thq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    thq_cmd_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = slot_reg[rd_ptr_reg];

    // Pointer and fill-count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/thq_back.sv */
`timescale 1ns / 1ps

module thq_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  thq_pkg::thq_cmd_t             cmd,
    input  logic                          queue_empty,
    output logic                          pop,
    input  logic [thq_pkg::SCALE_W-1:0]   height_scale,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [thq_pkg::OUT_W-1:0]     m_tdata,
    output logic                          m_tuser
);

    import thq_pkg::*;

    logic                 adv;

    // Bank ports
    logic [BANK_AW-1:0]   bank_addr  [NUM_BANKS];
    logic                 bank_we    [NUM_BANKS];
    logic [HEIGHT_W-1:0]  bank_rdata [NUM_BANKS];
    logic                 bank_re;

    // Stage B: corner heights arrive from the banks
    logic                 b_valid_reg;
    logic                 b_in_range_reg;
    logic                 b_lower_reg;
    logic                 b_x0_reg;
    logic                 b_z0_reg;
    logic [FRAC_BITS-1:0] b_fx_reg;
    logic [FRAC_BITS-1:0] b_fz_reg;

    // Stage C: interpolated height
    logic                 c_valid_reg;
    logic                 c_in_range_reg;
    logic [IACC_W-1:0]    c_acc_reg;
    logic [IACC_W-1:0]    c_acc_next;

    // Stage D: output register
    logic                 d_valid_reg;
    logic                 d_in_range_reg;
    logic [OUT_W-1:0]     d_height_reg;
    logic [OUT_W-1:0]     d_height_next;

    logic [HEIGHT_W-1:0]  h00;
    logic [HEIGHT_W-1:0]  h10;
    logic [HEIGHT_W-1:0]  h01;
    logic [HEIGHT_W-1:0]  h11;
    logic [HEIGHT_W-1:0]  base;
    logic signed [DIFF_W-1:0] diff_a;
    logic signed [DIFF_W-1:0] diff_b;
    logic signed [WGT_W:0]    wgt_a;
    logic signed [WGT_W:0]    wgt_b;
    logic signed [ACC_W-1:0]  part_a;
    logic signed [ACC_W-1:0]  part_b;
    logic signed [ACC_W-1:0]  acc;
    logic [PROD_W-1:0]        prod;

    // Whole pipeline moves unless the output register is held
    assign adv     = !d_valid_reg || m_tready;
    assign pop     = adv && !queue_empty;
    assign bank_re = pop && cmd.is_query;

    // Bank addressing: bank {bz,bx} holds vertices of that parity; each
    // corner of the cell lands in exactly one bank.
    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        logic [COORD_W-1:0]   cx;
        logic [COORD_W-1:0]   cz;
        logic [COORD_W-2:0]   xh;
        logic [COORD_W-2:0]   zh;

        assign cx = (cmd.x[0] == b[0]) ? cmd.x : cmd.x + 1'b1;
        assign cz = (cmd.z[0] == b[1]) ? cmd.z : cmd.z + 1'b1;
        assign xh = cx[COORD_W-1:1];
        assign zh = cz[COORD_W-1:1];

        assign bank_addr[b] = BANK_AW'(zh) * BANK_AW'(HALF) + BANK_AW'(xh);
        assign bank_we[b]   = pop && cmd.wr_en
                              && (cmd.x[0] == b[0]) && (cmd.z[0] == b[1]);

        thq_ram #(
            .WIDTH (HEIGHT_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[b]),
            .re    (bank_re),
            .addr  (bank_addr[b]),
            .wdata (cmd.sample),
            .rdata (bank_rdata[b])
        );
    end

    // Map banks back to cell corners
    assign h00 = bank_rdata[{b_z0_reg, b_x0_reg}];
    assign h10 = bank_rdata[{b_z0_reg, ~b_x0_reg}];
    assign h01 = bank_rdata[{~b_z0_reg, b_x0_reg}];
    assign h11 = bank_rdata[{~b_z0_reg, ~b_x0_reg}];

    // Triangle interpolation: lower uses h00 and the fractions, upper uses
    // h11 and the complements.
    always_comb
    begin
        if (b_lower_reg)
        begin
            base  = h00;
            wgt_a = {2'b00, b_fx_reg};
            wgt_b = {2'b00, b_fz_reg};
        end
        else
        begin
            base  = h11;
            wgt_a = (WGT_W + 1)'(ONE) - (WGT_W + 1)'(b_fx_reg);
            wgt_b = (WGT_W + 1)'(ONE) - (WGT_W + 1)'(b_fz_reg);
        end
        diff_a = $signed({1'b0, h10}) - $signed({1'b0, base});
        diff_b = $signed({1'b0, h01}) - $signed({1'b0, base});
        part_a = ACC_W'(diff_a) * ACC_W'(wgt_a);
        part_b = ACC_W'(diff_b) * ACC_W'(wgt_b);
        acc    = $signed(ACC_W'({base, {FRAC_BITS{1'b0}}})) + part_a + part_b;
        c_acc_next = acc[ACC_W-1] ? '0 : acc[IACC_W-1:0];
    end

    // Scale by the Q8.8 factor, zero outside the grid
    assign prod          = PROD_W'(c_acc_reg) * PROD_W'(height_scale);
    assign d_height_next = c_in_range_reg ? prod[FRAC_BITS +: OUT_W] : '0;

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= bank_re;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_in_range_reg <= cmd.in_range;
            b_lower_reg    <= cmd.lower;
            b_x0_reg       <= cmd.x[0];
            b_z0_reg       <= cmd.z[0];
            b_fx_reg       <= cmd.fx;
            b_fz_reg       <= cmd.fz;
            c_in_range_reg <= b_in_range_reg;
            c_acc_reg      <= c_acc_next;
            d_in_range_reg <= c_in_range_reg;
            d_height_reg   <= d_height_next;
        end
    end

    assign m_tvalid = d_valid_reg;
    assign m_tdata  = d_height_reg;
    assign m_tuser  = d_in_range_reg;

endmodule

/* rtl/terrain_height_query.sv */
`timescale 1ns / 1ps

// Height lookup over a triangulated heightmap grid.
// Slave stream (s_*): tuser selects the item kind; a write item stores one
// vertex height, a query asks for the height at a signed Q8.8 position.
// Master stream (m_*): one item per query, none per write; tdata carries
// the scaled height (Q16.8), tuser the in-range flag.
// Configuration channel (cfg_*): always ready; sets grid_width, grid_depth
// and height_scale. The user must use it only while the block is idle;
// the block does not enforce this. Throughput: one item per cycle, reads
// and writes alike, unless the receiver stalls; the four cell corners come
// from four parity-banked vertex memories in the same cycle. An accepted
// query goes via the queue, then bank read, interpolation and scaling.
// A four-entry queue parts the input classifier from the pipeline, so the
// input keeps accepting while a result waits; once the receiver stalls
// the pipeline holds and s_tready falls when the queue fills.
// Reset empties the queue and pipeline and restores the register
// defaults; the vertex store is not cleared and must be written before it
// is read.
module terrain_height_query (
    input  logic                              clk,
    input  logic                              rst_n,
    // Vertex writes and queries
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [8:0] vertex_x, [17:9] vertex_z, [25:18] height_sample,
    // [42:26] pos_x, [59:43] pos_z, [63:60] zero
    input  logic [63:0]                       s_tdata,
    // [0] kind
    input  logic                              s_tuser,
    // Query results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [23:0] surface_height
    output logic [23:0]                       m_tdata,
    // [0] in_range
    output logic                              m_tuser,
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [thq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                       cfg_data
);

    import thq_pkg::*;

    logic [COORD_W-1:0] grid_width_reg;
    logic [COORD_W-1:0] grid_depth_reg;
    logic [SCALE_W-1:0] height_scale_reg;

    logic               push;
    logic               pop;
    logic               queue_full;
    logic               queue_empty;
    thq_cmd_t           push_cmd;
    thq_cmd_t           pop_cmd;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg   <= COORD_W'(256);
            grid_depth_reg   <= COORD_W'(256);
            height_scale_reg <= SCALE_W'(256);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:   grid_width_reg   <= cfg_data[COORD_W-1:0];
                REG_GRID_DEPTH:   grid_depth_reg   <= cfg_data[COORD_W-1:0];
                REG_HEIGHT_SCALE: height_scale_reg <= cfg_data[SCALE_W-1:0];
                default:          ;
            endcase
        end
    end

    thq_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .grid_width (grid_width_reg),
        .grid_depth (grid_depth_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    thq_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    thq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (pop_cmd),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .height_scale (height_scale_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule

/* tb/terrain_height_query_test.sv */
`timescale 1ns / 1ps

module terrain_height_query_test;
    import thq_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int STRIDE       = MAX_CELLS + 1;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS  = 320;
    localparam int NUM_PHASES   = 6;
    localparam int REPORT_MAX   = 10;

    // Index 3 has no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic                kind;
        logic [COORD_W-1:0]  vertex_x;
        logic [COORD_W-1:0]  vertex_z;
        logic [HEIGHT_W-1:0] height_sample;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_z;
    } terrain_item_t;

    typedef struct {
        logic [OUT_W-1:0] surface_height;
        logic             in_range;
    } height_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;

    // Shadow of the vertex store and registers, updated as items are taken
    logic [HEIGHT_W-1:0]  vertex_heights [STRIDE*STRIDE];
    bit                   vertex_planned [STRIDE*STRIDE];
    logic [COORD_W-1:0]   grid_width_reg;
    logic [COORD_W-1:0]   grid_depth_reg;
    logic [SCALE_W-1:0]   height_scale_reg;

    terrain_item_t        pending_items[$];
    height_result_t       expected_heights[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int queued_items = 0;
    bit offer_taken = 1'b0;

    terrain_height_query DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Height the block should return for a query at (px, pz)
    function automatic height_result_t predict_height(input logic [POS_W-1:0] px,
                                                      input logic [POS_W-1:0] pz);
        height_result_t res;
        int w, d, ix, iz, fx, fz, base;
        int h00, h10, h01, h11, acc;
        longint scaled;
        res.surface_height = '0;
        res.in_range = 1'b0;
        w = (grid_width_reg > MAX_CELLS) ? MAX_CELLS : grid_width_reg;
        d = (grid_depth_reg > MAX_CELLS) ? MAX_CELLS : grid_depth_reg;
        if (px[POS_W-1] || pz[POS_W-1])
            return res;
        ix = px[POS_W-2:FRAC_BITS];
        iz = pz[POS_W-2:FRAC_BITS];
        if (ix >= w || iz >= d)
            return res;
        fx = px[FRAC_BITS-1:0];
        fz = pz[FRAC_BITS-1:0];
        base = iz * STRIDE + ix;
        h00 = vertex_heights[base];
        h10 = vertex_heights[base + 1];
        h01 = vertex_heights[base + STRIDE];
        h11 = vertex_heights[base + STRIDE + 1];
        // Lower triangle up to and including the diagonal
        if (fx + fz <= ONE)
            acc = h00 * ONE + (h10 - h00) * fx + (h01 - h00) * fz;
        else
            acc = h11 * ONE + (h10 - h11) * (ONE - fx) + (h01 - h11) * (ONE - fz);
        if (acc < 0)
            acc = 0;
        scaled = (longint'(acc) * longint'(height_scale_reg)) >>> FRAC_BITS;
        if (scaled > 64'hFFFFFF)
            scaled = 64'hFFFFFF;
        res.surface_height = OUT_W'(scaled);
        res.in_range = 1'b1;
        return res;
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic queue_write(input int x, input int z, input int h);
        terrain_item_t it;
        it.kind = KIND_WRITE;
        it.vertex_x = COORD_W'(x);
        it.vertex_z = COORD_W'(z);
        it.height_sample = HEIGHT_W'(h);
        it.pos_x = POS_W'($urandom);
        it.pos_z = POS_W'($urandom);
        pending_items.push_back(it);
        queued_items++;
        if (x <= MAX_CELLS && z <= MAX_CELLS)
            vertex_planned[z * STRIDE + x] = 1'b1;
    endtask

    // A query inside the grid is preceded by writes of any corner not yet set
    task automatic queue_query(input logic [POS_W-1:0] px, input logic [POS_W-1:0] pz);
        terrain_item_t it;
        int w, d, ix, iz;
        w = (grid_width_reg > MAX_CELLS) ? MAX_CELLS : grid_width_reg;
        d = (grid_depth_reg > MAX_CELLS) ? MAX_CELLS : grid_depth_reg;
        ix = px[POS_W-2:FRAC_BITS];
        iz = pz[POS_W-2:FRAC_BITS];
        if (!px[POS_W-1] && !pz[POS_W-1] && ix < w && iz < d)
        begin
            for (int dz = 0; dz < 2; dz++)
            begin
                for (int dx = 0; dx < 2; dx++)
                begin
                    if (!vertex_planned[(iz + dz) * STRIDE + ix + dx])
                        queue_write(ix + dx, iz + dz, $urandom_range(255));
                end
            end
        end
        it.kind = KIND_QUERY;
        it.vertex_x = COORD_W'($urandom);
        it.vertex_z = COORD_W'($urandom);
        it.height_sample = HEIGHT_W'($urandom);
        it.pos_x = px;
        it.pos_z = pz;
        pending_items.push_back(it);
        queued_items++;
    endtask

    // Cell index near either edge of the grid, or anywhere in it
    function automatic int pick_cell(input int n);
        int span;
        span = (n < 8) ? n : 8;
        case ($urandom_range(2))
            0:       return $urandom_range(span - 1);
            1:       return n - 1 - $urandom_range(span - 1);
            default: return $urandom_range(n - 1);
        endcase
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value[15:0];
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Wait until every item is taken and every result is back
    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_heights.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register shadow
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg = 9'd256;
            grid_depth_reg = 9'd256;
            height_scale_reg = 16'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:   grid_width_reg = cfg_data[COORD_W-1:0];
                REG_GRID_DEPTH:   grid_depth_reg = cfg_data[COORD_W-1:0];
                REG_HEIGHT_SCALE: height_scale_reg = cfg_data;
                default:          ;
            endcase
        end
    end

    // Input items taken: update the store shadow or queue the expected height
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            if (pending_items[0].kind == KIND_WRITE)
            begin
                if (pending_items[0].vertex_x <= MAX_CELLS
                    && pending_items[0].vertex_z <= MAX_CELLS)
                    vertex_heights[pending_items[0].vertex_z * STRIDE
                                   + pending_items[0].vertex_x]
                        = pending_items[0].height_sample;
            end
            else
                expected_heights.push_back(predict_height(pending_items[0].pos_x,
                                                          pending_items[0].pos_z));
            void'(pending_items.pop_front());
            offer_taken = 1'b1;
        end
    end

    // Sender
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !offer_taken)
        begin
            // item still on offer, hold it
        end
        else if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            s_tvalid <= 1'b1;
            s_tuser <= pending_items[0].kind;
            s_tdata <= {4'b0, pending_items[0].pos_z, pending_items[0].pos_x,
                        pending_items[0].height_sample, pending_items[0].vertex_z,
                        pending_items[0].vertex_x};
        end
        else
            s_tvalid <= 1'b0;
        offer_taken = 1'b0;
    end

    // Receiver, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result check against the oldest expected height
    always @(posedge clk)
    begin : result_check
        height_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_heights.size() == 0)
                flag_error($sformatf("unexpected result: height %0d in_range %0b",
                                     m_tdata, m_tuser));
            else
            begin
                want = expected_heights.pop_front();
                if (m_tdata !== want.surface_height || m_tuser !== want.in_range)
                    flag_error($sformatf("result mismatch: height exp %0d got %0d, in_range exp %0b got %0b",
                                         want.surface_height, m_tdata,
                                         want.in_range, m_tuser));
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int r, w, d, cx, cz, fx, fz;
        int phase_start;
        bit paused;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items at reset settings
        send_idle_pct = 25;
        recv_idle_pct = 83;
        queue_write(0, 0, 0);
        queue_write(1, 0, 255);
        queue_write(0, 1, 128);
        queue_write(1, 1, 64);
        queue_query(17'h00000, 17'h00000);   // on a vertex
        queue_query(17'h00080, 17'h00080);   // on the diagonal, lower triangle
        queue_query(17'h00081, 17'h00080);   // just past the diagonal
        queue_query(17'h000FF, 17'h000FF);   // far corner of the cell
        queue_query(17'h000FF, 17'h00001);
        queue_write(255, 255, 255);
        queue_write(256, 255, 0);
        queue_write(255, 256, 255);
        queue_write(256, 256, 17);
        queue_query(17'h0FFFF, 17'h0FFFF);   // furthest point inside the grid
        queue_query(17'h10000, 17'h00000);   // most negative x
        queue_query(17'h00000, 17'h1FFFF);   // z just below zero
        queue_write(511, 3, 99);             // beyond the store, dropped
        queue_write(2, 257, 99);
        queue_write(0, 0, 255);
        queue_query(17'h00080, 17'h00000);
        queue_query(17'h0FF80, 17'h0FF10);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            case (p)
                0:
                begin
                    write_register(REG_GRID_WIDTH, 256);
                    write_register(REG_GRID_DEPTH, 256);
                    write_register(REG_HEIGHT_SCALE, 65535);
                end
                1:
                begin
                    write_register(REG_GRID_WIDTH, 1);
                    write_register(REG_GRID_DEPTH, 1);
                    write_register(REG_HEIGHT_SCALE, 0);
                end
                2:
                begin
                    write_register(REG_GRID_WIDTH, 511);
                    write_register(REG_UNUSED, $urandom_range(65535));
                    write_register(REG_GRID_DEPTH, 16);
                    write_register(REG_HEIGHT_SCALE, 384);
                end
                3:
                begin
                    write_register(REG_GRID_WIDTH, 20);
                    write_register(REG_GRID_DEPTH, 256);
                    write_register(REG_HEIGHT_SCALE, 1);
                end
                4:
                begin
                    write_register(REG_GRID_WIDTH, 0);
                    write_register(REG_GRID_DEPTH, 300);
                    write_register(REG_HEIGHT_SCALE, 256);
                end
                default:
                begin
                    write_register(REG_GRID_WIDTH, $urandom_range(1, 256));
                    write_register(REG_GRID_DEPTH, $urandom_range(1, 256));
                    write_register(REG_HEIGHT_SCALE, $urandom_range(65535));
                end
            endcase
            @(negedge clk);
            cfg_valid = 1'b0;

            // Idle pattern: sender light / receiver heavy, then swapped, then none
            send_idle_pct = (p < 2) ? 25 : (p < 4) ? 83 : 0;
            recv_idle_pct = (p < 2) ? 83 : (p < 4) ? 25 : 0;
            if (p == NUM_PHASES - 1)
                hold_requests++;

            w = (grid_width_reg > MAX_CELLS) ? MAX_CELLS : grid_width_reg;
            d = (grid_depth_reg > MAX_CELLS) ? MAX_CELLS : grid_depth_reg;
            if (w == 0)
                w = 1;
            if (d == 0)
                d = 1;

            // Corner writes count towards the phase budget
            phase_start = queued_items;
            paused = 1'b0;
            while (queued_items - phase_start < PHASE_ITEMS)
            begin
                // sender pauses once until everything has come back
                if (p == 1 && !paused && queued_items - phase_start >= PHASE_ITEMS / 2)
                begin
                    wait_idle();
                    paused = 1'b1;
                end
                r = $urandom_range(99);
                if (r < 18)
                begin
                    if ($urandom_range(3) == 0)
                        queue_write($urandom_range(511), $urandom_range(511),
                                    $urandom_range(255));
                    else
                        queue_write($urandom_range(MAX_CELLS), $urandom_range(MAX_CELLS),
                                    $urandom_range(255));
                end
                else if (r < 30)
                    queue_query(POS_W'($urandom), POS_W'($urandom));
                else
                begin
                    cx = pick_cell(w);
                    cz = pick_cell(d);
                    case ($urandom_range(3))
                        0:
                        begin
                            fx = $urandom_range(ONE - 1);
                            fz = $urandom_range(ONE - 1);
                        end
                        1:
                        begin
                            fx = $urandom_range(1, ONE - 1);
                            fz = ONE - fx;
                        end
                        2:
                        begin
                            fx = $urandom_range(2, ONE - 1);
                            fz = ONE + 1 - fx;
                        end
                        default:
                        begin
                            fx = $urandom_range(1) * (ONE - 1);
                            fz = $urandom_range(1) * (ONE - 1);
                        end
                    endcase
                    queue_query(POS_W'(cx * ONE + fx), POS_W'(cz * ONE + fz));
                end
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
